FILE: rtl/bgd_pkg.sv
// Shared types and constants for the GBRG Bayer 5x5 demosaic block.
`default_nettype none

package bgd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int WIN       = 5;

    // Queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Kernel numerator, gain product and output scaling
    localparam int NUM_W    = 22;
    localparam int PROD_W   = NUM_W + CFG_W + 1;
    localparam int XC_W     = 21;
    localparam int Y_W      = 19;
    localparam int SAT_TOP  = 1023 * 2048;
    localparam int ROUND    = 511 * 2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_SAMPLE_SHIFT = 3'd2,
        REG_RED_GAIN     = 3'd3,
        REG_GREEN_GAIN   = 3'd4,
        REG_BLUE_GAIN    = 3'd5
    } t_reg_idx;

    // Position of an arriving column within its row
    typedef enum logic [1:0] {
        COL_FIRST,
        COL_SECOND,
        COL_THIRD,
        COL_REST
    } t_col_kind;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [WIN-1:0]   t_column;   // index 0 is the top row

    typedef struct packed {
        t_column   col;
        t_col_kind kind;
        logic      emit;
        logic      row_odd;
        logic      col_odd;
        logic      eof;
    } t_col_job;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: rtl/bayer_gbrg_demosaic_5x5.sv
// Top level of the streaming GBRG Bayer 5x5 demosaic with gains and 8-bit scaling.
`default_nettype none

// Takes a GBRG Bayer frame in raster order, one 16-bit raw sample per transfer,
// shifts it right by sample_shift and stores it in five line banks of MAX_WIDTH
// x 16 bits (one bank per row slot, no clearing pass: every position read for a
// pixel has been written earlier in the same frame). Each accepted item writes
// one sample and fetches one five-row column; the back end slides a 5x5 window
// with edge replication, applies the Malvar-style kernels, multiplies by the
// 4.8 channel gains, clamps to 0..1023 and scales to 8 bits. The pixel with
// raster index p leaves with the item number p+2W+2, so a frame is followed by
// 2W+2 flush items. Sustained rate is one item per clock. An item passes the
// line-bank fetch register and the queue, then four back-end stages: window
// and kernel, gain multiply, clamp and scale, divide by 1023. Only output
// stalls slow it down: a stalled output freezes the back end, and the input
// stalls once the four-entry queue and the fetch stage together hold four
// columns. The queue separates front and back so either side can stall on its
// own. Writing frame_width or frame_height restarts the frame; the user must
// write configuration only while the block is idle; the block itself does
// not enforce this.
module bayer_gbrg_demosaic_5x5 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_raw_sample,
    input  wire logic        i_flush,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_end_of_frame
);
    import bgd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT) + 1;

    // configuration registers
    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic [3:0]  r_sample_shift;
    logic [11:0] r_red_gain;
    logic [11:0] r_green_gain;
    logic [11:0] r_blue_gain;

    logic        restart;
    logic [13:0] fw14, fh14;
    logic [13:0] eff_w14, eff_h14;
    logic [CW:0] eff_w;
    logic [HW-1:0] eff_h;

    logic     q_push;
    logic     q_pop;
    t_col_job f_job;
    t_col_job q_head;
    t_q_stat  q_stat;

    // a size write restarts the raster counters at the same edge
    assign restart = i_cfg_we && ((t_reg_idx'(i_cfg_index) == REG_FRAME_WIDTH) ||
                                  (t_reg_idx'(i_cfg_index) == REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd640;
            r_frame_height <= 12'd480;
            r_sample_shift <= 4'd0;
            r_red_gain     <= 12'd1280;
            r_green_gain   <= 12'd1152;
            r_blue_gain    <= 12'd1229;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                REG_SAMPLE_SHIFT: r_sample_shift <= i_cfg_data[3:0];
                REG_RED_GAIN:     r_red_gain     <= i_cfg_data;
                REG_GREEN_GAIN:   r_green_gain   <= i_cfg_data;
                REG_BLUE_GAIN:    r_blue_gain    <= i_cfg_data;
                default:          ;   // unused index, write dropped
            endcase
        end
    end

    // sizes saturate to 4..MAX
    assign fw14 = 14'(r_frame_width);
    assign fh14 = 14'(r_frame_height);
    assign eff_w14 = (fw14 < 14'd4) ? 14'd4 :
                     (fw14 > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : fw14;
    assign eff_h14 = (fh14 < 14'd4) ? 14'd4 :
                     (fh14 > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : fh14;
    assign eff_w = eff_w14[CW:0];
    assign eff_h = eff_h14[HW-1:0];

    bgd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_width      (eff_w),
        .i_height     (eff_h),
        .i_shift      (r_sample_shift),
        .i_valid      (i_in_valid),
        .i_raw_sample (i_raw_sample),
        .i_flush      (i_flush),
        .i_qstat      (q_stat),
        .o_stall      (o_in_stall),
        .o_push       (q_push),
        .o_job        (f_job)
    );

    bgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bgd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_qstat      (q_stat),
        .i_red_gain   (r_red_gain),
        .i_green_gain (r_green_gain),
        .i_blue_gain  (r_blue_gain),
        .i_out_stall  (i_out_stall),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_eof        (o_end_of_frame)
    );

    // front's credit check must keep the queue from overflowing
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full && !q_pop))
        else $error("column queue overflow");

    // back end pops only when a column is waiting
    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("column queue underflow");

endmodule

`default_nettype wire

FILE: rtl/bgd_front.sv
// Front end: raster counters, five line banks and column fetch for the demosaic.
`default_nettype none

module bgd_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int HW = $clog2(MAX_HEIGHT) + 1,
    localparam int RW = HW + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_restart,
    input  wire logic [CW:0]       i_width,
    input  wire logic [HW-1:0]     i_height,
    input  wire logic [3:0]        i_shift,
    input  wire logic              i_valid,
    input  wire logic [15:0]       i_raw_sample,
    input  wire logic              i_flush,
    input  wire bgd_pkg::t_q_stat  i_qstat,
    output logic                   o_stall,
    output logic                   o_push,
    output bgd_pkg::t_col_job      o_job
);
    import bgd_pkg::*;

    logic [RW-1:0]   r_in_row, n_in_row;
    logic [CW-1:0]   r_in_col, n_in_col;
    logic [HW-1:0]   r_out_row, n_out_row;
    logic [CW-1:0]   r_out_col, n_out_col;
    logic [2:0]      r_ib, n_ib;
    logic [2:0]      r_lastb, n_lastb;

    logic            accept;
    logic [QCNT_W:0] used;
    logic [RW-1:0]   h_ext;
    logic            wr_en;
    t_sample         wdata;
    logic            emit;
    logic            col_last;
    logic            out_col_last;
    logic            eof;
    t_col_kind       kind;
    logic [2:0]      sel [WIN];
    logic            byp [WIN];

    t_sample         rd_bank [WIN];

    logic            r_f2_valid;
    logic [2:0]      r_f2_sel [WIN];
    logic            r_f2_byp [WIN];
    t_sample         r_f2_wdata;
    t_col_kind       r_f2_kind;
    logic            r_f2_emit;
    logic            r_f2_rodd;
    logic            r_f2_codd;
    logic            r_f2_eof;

    // room for the item in the fetch stage plus a new one
    assign used    = {1'b0, i_qstat.count} + {{QCNT_W{1'b0}}, r_f2_valid};
    assign o_stall = (used >= (QCNT_W+1)'(QDEPTH));
    assign accept  = i_valid && !o_stall;

    assign h_ext   = RW'(i_height);
    assign wr_en   = accept && (r_in_row < h_ext);
    assign wdata   = i_flush ? '0 : (i_raw_sample >> i_shift);
    assign emit    = (r_in_row > RW'(2)) || ((r_in_row == RW'(2)) && (r_in_col >= CW'(2)));

    assign col_last     = ((CW+1)'(r_in_col) + (CW+1)'(1)) == i_width;
    assign out_col_last = ((CW+1)'(r_out_col) + (CW+1)'(1)) == i_width;
    assign eof          = (r_out_row == (i_height - HW'(1))) && out_col_last;

    always_comb begin
        if (r_in_col == CW'(0)) begin
            kind = COL_FIRST;
        end else if (r_in_col == CW'(1)) begin
            kind = COL_SECOND;
        end else if (r_in_col == CW'(2)) begin
            kind = COL_THIRD;
        end else begin
            kind = COL_REST;
        end
    end

    // bank of each window row, with rows clamped to the frame
    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            if (r_in_row < RW'(k)) begin
                sel[k] = 3'd0;
            end else if (r_in_row >= h_ext + RW'(k)) begin
                sel[k] = r_lastb;
            end else if (r_ib >= 3'(k)) begin
                sel[k] = r_ib - 3'(k);
            end else begin
                sel[k] = r_ib + 3'(WIN - k);
            end
            byp[k] = wr_en && (sel[k] == r_ib);
        end
    end

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_ib      = r_ib;
        n_lastb   = r_lastb;
        if (accept) begin
            if (wr_en && (r_in_row == h_ext - RW'(1))) begin
                n_lastb = r_ib;
            end
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
                n_ib     = (r_ib == 3'd4) ? 3'd0 : r_ib + 3'd1;
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (eof) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                    n_ib      = '0;
                end else if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + HW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
        if (i_restart) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
            n_ib      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_ib       <= '0;
            r_lastb    <= '0;
            r_f2_valid <= 1'b0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_ib       <= n_ib;
            r_lastb    <= n_lastb;
            r_f2_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f2_sel   <= sel;
            r_f2_byp   <= byp;
            r_f2_wdata <= wdata;
            r_f2_kind  <= kind;
            r_f2_emit  <= emit;
            r_f2_rodd  <= r_out_row[0];
            r_f2_codd  <= r_out_col[0];
            r_f2_eof   <= emit && eof;
        end
    end

    // one line bank per row slot, read and written at the same column
    for (genvar b = 0; b < WIN; b++) begin : g_bank
        t_sample r_mem [MAX_WIDTH];
        t_sample r_rd;
        always_ff @(posedge i_clk) begin
            if (wr_en && (r_ib == 3'(b))) begin
                r_mem[r_in_col] <= wdata;
            end
            if (accept) begin
                r_rd <= r_mem[r_in_col];
            end
        end
        assign rd_bank[b] = r_rd;
    end

    always_comb begin
        o_job.kind    = r_f2_kind;
        o_job.emit    = r_f2_emit;
        o_job.row_odd = r_f2_rodd;
        o_job.col_odd = r_f2_codd;
        o_job.eof     = r_f2_eof;
        for (int k = 0; k < WIN; k++) begin
            o_job.col[WIN-1-k] = r_f2_byp[k] ? r_f2_wdata : rd_bank[r_f2_sel[k]];
        end
    end

    assign o_push = r_f2_valid;

endmodule

`default_nettype wire

FILE: rtl/bgd_queue.sv
// Short column queue between the demosaic front end and back end.
`default_nettype none

module bgd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bgd_pkg::t_col_job i_job,
    input  wire logic              i_pop,
    output bgd_pkg::t_col_job      o_head,
    output bgd_pkg::t_q_stat       o_stat
);
    import bgd_pkg::*;

    t_col_job          r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

FILE: rtl/bgd_back.sv
// Back end: 5x5 window, color kernels, gains and 8-bit scaling.
`default_nettype none

module bgd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bgd_pkg::t_col_job i_head,
    input  wire bgd_pkg::t_q_stat  i_qstat,
    input  wire logic [11:0]       i_red_gain,
    input  wire logic [11:0]       i_green_gain,
    input  wire logic [11:0]       i_blue_gain,
    input  wire logic              i_out_stall,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic                   o_eof
);
    import bgd_pkg::*;

    function automatic logic signed [NUM_W-1:0] sx(input t_sample v);
        return $signed(NUM_W'(v));
    endfunction

    function automatic logic [Y_W-1:0] scale_y(input logic signed [PROD_W-1:0] x);
        logic [XC_W-1:0] xc;
        logic [29:0]     y;
        if (x <= $signed(PROD_W'(0))) begin
            xc = '0;
        end else if (x > $signed(PROD_W'(SAT_TOP))) begin
            xc = XC_W'(SAT_TOP);
        end else begin
            xc = x[XC_W-1:0];
        end
        y = (30'(xc) << 8) - 30'(xc) + 30'(ROUND);
        return y[29:11];
    endfunction

    // divide by 1023: estimate from 1/1024 + 1/1024^2, then one correction
    function automatic logic [7:0] div1023(input logic [Y_W-1:0] y);
        logic [19:0] qs;
        logic [9:0]  q0;
        logic [19:0] m;
        logic [19:0] rem;
        logic [9:0]  q;
        qs  = 20'(y) + 20'(y >> 10);
        q0  = qs[19:10];
        m   = (20'(q0) << 10) - 20'(q0);
        rem = 20'(y) - m;
        q   = (rem >= 20'd1023) ? q0 + 10'd1 : q0;
        return q[7:0];
    endfunction

    logic    adv;
    t_column r_win [WIN];
    t_column r_p0;
    t_column r_p1;
    t_column cw [WIN];

    logic signed [NUM_W-1:0] p8, cross4, diag, vert, hor, vfar, hfar;
    logic signed [NUM_W-1:0] rn, gn, bn;

    logic                     r_a_valid, r_a_eof;
    logic signed [NUM_W-1:0]  r_a_rn, r_a_gn, r_a_bn;
    logic                     r_b_valid, r_b_eof;
    logic signed [PROD_W-1:0] r_b_r, r_b_g, r_b_b;
    logic                     r_c_valid, r_c_eof;
    logic [Y_W-1:0]           r_c_r, r_c_g, r_c_b;
    logic                     r_d_valid;

    assign adv   = !(r_d_valid && i_out_stall);
    assign o_pop = adv && !i_qstat.empty;

    // window columns C-2..C+2 for the pixel this column completes
    always_comb begin
        case (i_head.kind)
            COL_FIRST, COL_SECOND: cw = '{r_win[1], r_win[2], r_win[3], r_win[4], r_win[4]};
            COL_THIRD:             cw = '{r_p0, r_p0, r_p0, r_p1, i_head.col};
            COL_REST:              cw = '{r_win[1], r_win[2], r_win[3], r_win[4], i_head.col};
            default:               cw = '{r_win[1], r_win[2], r_win[3], r_win[4], i_head.col};
        endcase
    end

    always_comb begin
        p8     = sx(cw[2][2]) <<< 3;
        vfar   = sx(cw[2][0]) + sx(cw[2][4]);
        hfar   = sx(cw[0][2]) + sx(cw[4][2]);
        vert   = p8 + ((sx(cw[2][1]) + sx(cw[2][3])) <<< 1) - vfar;
        hor    = p8 + ((sx(cw[1][2]) + sx(cw[3][2])) <<< 1) - hfar;
        cross4 = p8 + ((sx(cw[2][1]) + sx(cw[2][3]) + sx(cw[1][2]) + sx(cw[3][2])) <<< 1)
               - vfar - hfar;
        diag   = p8 + ((sx(cw[1][1]) + sx(cw[3][1]) + sx(cw[1][3]) + sx(cw[3][3])) <<< 1)
               - vfar - hfar;
        case ({i_head.row_odd, i_head.col_odd})
            2'b10: begin        // red site
                rn = p8;   gn = cross4; bn = diag;
            end
            2'b01: begin        // blue site
                rn = diag; gn = cross4; bn = p8;
            end
            2'b00: begin        // green on blue row
                rn = vert; gn = p8;     bn = hor;
            end
            default: begin      // green on red row
                rn = hor;  gn = p8;     bn = vert;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_win <= cw;
            if (i_head.kind == COL_FIRST) begin
                r_p0 <= i_head.col;
            end
            if (i_head.kind == COL_SECOND) begin
                r_p1 <= i_head.col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= o_pop && i_head.emit;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_rn  <= rn;
            r_a_gn  <= gn;
            r_a_bn  <= bn;
            r_a_eof <= i_head.eof;
            r_b_r   <= r_a_rn * $signed({1'b0, i_red_gain});
            r_b_g   <= r_a_gn * $signed({1'b0, i_green_gain});
            r_b_b   <= r_a_bn * $signed({1'b0, i_blue_gain});
            r_b_eof <= r_a_eof;
            r_c_r   <= scale_y(r_b_r);
            r_c_g   <= scale_y(r_b_g);
            r_c_b   <= scale_y(r_b_b);
            r_c_eof <= r_b_eof;
            o_red   <= div1023(r_c_r);
            o_green <= div1023(r_c_g);
            o_blue  <= div1023(r_c_b);
            o_eof   <= r_c_eof;
        end
    end

    assign o_out_valid = r_d_valid;

endmodule

`default_nettype wire
